@@ rtl/utc_pkg.sv @@
// shared widths, division constants and small tables for the unix time to calendar block
`default_nettype none

package utc_pkg;

	// pipeline shape
	localparam int unsigned NUM_STG   = 10;
	localparam int unsigned SPLIT_STG = 3;

	// port field widths
	localparam int unsigned SEC_W   = 32;
	localparam int unsigned SECF_W  = 6;
	localparam int unsigned MINF_W  = 6;
	localparam int unsigned HOURF_W = 5;
	localparam int unsigned WD_W    = 3;
	localparam int unsigned DOM_W   = 5;
	localparam int unsigned MON_W   = 4;
	localparam int unsigned YR_W    = 12;

	// seconds to days: 86400 = 675 << 7, quotient estimate by reciprocal
	localparam int unsigned DAY_SHIFT = 7;
	localparam int unsigned HI_W      = SEC_W - DAY_SHIFT;
	localparam int unsigned DAY_W     = 16;
	localparam int unsigned TOD_W     = 17;
	localparam int unsigned DREM_W    = 11;
	localparam int unsigned DREC_W    = 16;
	localparam int unsigned PDAY_W    = HI_W + DREC_W;
	localparam int unsigned DAY_REC_S = 25;
	localparam logic [DREC_W-1:0] DAY_REC = 16'd49710;
	localparam logic [9:0]        DAY_ODD = 10'd675;

	// weekday: (days + 3) mod 7
	localparam int unsigned WX_W  = 17;
	localparam int unsigned WP_W  = 32;
	localparam int unsigned WD_S  = 17;
	localparam int unsigned WQ_W  = 13;
	localparam int unsigned WR_W  = 4;
	localparam logic [WX_W-1:0] WD_OFF  = 17'd3;
	localparam logic [14:0]     WD_REC  = 15'd18724;
	localparam logic [WR_W-1:0] WD_DAYS = 4'd7;

	// time of day split
	localparam int unsigned TOD_S = 17;
	localparam int unsigned PH_W  = 23;
	localparam int unsigned PM_W  = 29;
	localparam int unsigned HQ_W  = 5;
	localparam int unsigned HR_W  = 13;
	localparam int unsigned TQ_W  = 11;
	localparam int unsigned TR_W  = 7;
	localparam logic [5:0]       HR_REC   = 6'd36;
	localparam logic [11:0]      TM_REC   = 12'd2184;
	localparam logic [HR_W-1:0]  SEC_HOUR = 13'd3600;
	localparam logic [TR_W-1:0]  SEC_MIN  = 7'd60;

	// julian day to gregorian date
	localparam int unsigned A_W = 22;
	localparam int unsigned C_W = 16;
	localparam logic [A_W-1:0] A_OFF = 22'd2472632;
	localparam logic [A_W-1:0] B67_A = 22'd2447124;
	localparam logic [A_W-1:0] B68_A = 22'd2483649;
	localparam logic [A_W-1:0] B69_A = 22'd2520173;

	localparam int unsigned XD_W = 18;
	localparam int unsigned PD_W = 26;
	localparam int unsigned D_S  = 18;
	localparam int unsigned DQ_W = 7;
	localparam int unsigned DR_W = 12;
	localparam logic [7:0]      D_REC     = 8'd179;
	localparam logic [DR_W-1:0] DAYS_4Y   = 12'd1461;
	localparam int unsigned E_W  = 9;

	localparam int unsigned XM_W  = 11;
	localparam int unsigned PMQ_W = 15;
	localparam int unsigned M_S   = 11;
	localparam int unsigned MQ_W  = 4;
	localparam int unsigned MR_W  = 9;
	localparam logic [3:0]      M_REC   = 4'd13;
	localparam logic [MR_W-1:0] DAYS_5M = 9'd153;
	localparam logic [MQ_W-1:0] M_WRAP  = 4'd10;

	typedef enum logic [1:0] {
		CENT_1900,
		CENT_2000,
		CENT_2100
	} cent_t;

	typedef struct packed {
		logic [SECF_W-1:0]  second;
		logic [MINF_W-1:0]  minute;
		logic [HOURF_W-1:0] hour;
		logic [WD_W-1:0]    weekday;
	} tod_t;

	// year offset for each 100-year block index, less 4800
	function automatic logic [YR_W-1:0] year_base(input cent_t cent);
		logic [YR_W-1:0] base;
		case (cent)
			CENT_1900: base = 12'd1900;
			CENT_2000: base = 12'd2000;
			CENT_2100: base = 12'd2100;
			default:   base = 12'd1900;
		endcase
		return base;
	endfunction

	// (153 * m + 2) / 5 for march-based month index m
	function automatic logic [E_W-1:0] month_start(input logic [MQ_W-1:0] m);
		logic [E_W-1:0] start;
		case (m)
			4'd0:    start = 9'd0;
			4'd1:    start = 9'd31;
			4'd2:    start = 9'd61;
			4'd3:    start = 9'd92;
			4'd4:    start = 9'd122;
			4'd5:    start = 9'd153;
			4'd6:    start = 9'd184;
			4'd7:    start = 9'd214;
			4'd8:    start = 9'd245;
			4'd9:    start = 9'd275;
			4'd10:   start = 9'd306;
			4'd11:   start = 9'd337;
			default: start = 9'd0;
		endcase
		return start;
	endfunction

endpackage

`default_nettype wire

@@ rtl/utc_if.sv @@
// request channels: timestamp in, calendar fields out
`default_nettype none

interface utc_stamp_if;
	logic                          valid;
	logic                          ready;
	logic [utc_pkg::SEC_W-1:0]     unix_seconds;

	modport source (output valid, output unix_seconds, input ready);
	modport sink   (input valid, input unix_seconds, output ready);
endinterface

interface utc_cal_if;
	logic                          valid;
	logic                          ready;
	logic [utc_pkg::SECF_W-1:0]    second_of_minute;
	logic [utc_pkg::MINF_W-1:0]    minute_of_hour;
	logic [utc_pkg::HOURF_W-1:0]   hour_of_day;
	logic [utc_pkg::WD_W-1:0]      weekday;
	logic [utc_pkg::DOM_W-1:0]     day_of_month;
	logic [utc_pkg::MON_W-1:0]     month_number;
	logic [utc_pkg::YR_W-1:0]      year_number;

	modport source (output valid, output second_of_minute, output minute_of_hour,
		output hour_of_day, output weekday, output day_of_month, output month_number,
		output year_number, input ready);
	modport sink   (input valid, input second_of_minute, input minute_of_hour,
		input hour_of_day, input weekday, input day_of_month, input month_number,
		input year_number, output ready);
endinterface

`default_nettype wire

@@ rtl/unix_time_to_calendar.sv @@
// top level: unix seconds to time of day, weekday and gregorian date
//
// Usage:
//   stamp carries one 32-bit count of seconds since 1970-01-01 00:00 UTC per
//   request; cal returns seconds, minutes, hours, weekday (0 Monday), day of
//   month, month and year for it. Every request gives exactly one result, in
//   order. Both channels use valid/ready; a request moves on a clock edge with
//   both high.
//   A result passes through the ten register stages (day split, reciprocal
//   quotient estimates, their correction steps and the month stage) before it
//   shows on cal. Throughput is one request per cycle while cal.ready does
//   not hold the results back.
//   Each stage has its own valid bit and loads when empty or when its
//   successor moves, so bubbles close up and stamp.ready stays high while any
//   stage is free, even with a finished result held on cal.
//   When cal.ready is low the results hold steady; once every stage is full
//   stamp.ready drops, and nothing is lost or repeated.
//   arst_n clears all valid bits at once; the data registers are not reset,
//   and the block accepts requests in the first cycle after reset is released.
`default_nettype none

module unix_time_to_calendar (
	input  logic            clk,
	input  logic            arst_n,
	utc_stamp_if.sink       stamp,
	utc_cal_if.source       cal
);
	import utc_pkg::*;

	logic [NUM_STG-1:0] adv;
	logic [DAY_W-1:0]   days;
	logic [TOD_W-1:0]   tod;

	// pipeline handshake
	utc_pipe_ctl #(
		.NUM_STAGES (NUM_STG)
	) u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (stamp.valid),
		.in_ready  (stamp.ready),
		.out_valid (cal.valid),
		.out_ready (cal.ready),
		.adv       (adv)
	);

	// stages 1 to 3: days and seconds of the day
	utc_day_split u_split (
		.clk          (clk),
		.adv          (adv[SPLIT_STG-1:0]),
		.unix_seconds (stamp.unix_seconds),
		.days         (days),
		.tod          (tod)
	);

	// stage registers
	logic [WX_W-1:0]   wx_s4;
	logic [WP_W-1:0]   pw_s4;
	logic [TOD_W-1:0]  tod_s4;
	logic [PH_W-1:0]   ph_s4;
	logic [PM_W-1:0]   pm_s4;
	logic [C_W-1:0]    c_s4;
	cent_t             cent_s4;

	logic [WR_W-1:0]   wr_s5;
	logic [HQ_W-1:0]   hq_s5;
	logic [HR_W-1:0]   hr_s5;
	logic [TQ_W-1:0]   tq_s5;
	logic [TR_W-1:0]   tr_s5;
	logic [XD_W-1:0]   xd_s5;
	logic [PD_W-1:0]   pd_s5;
	cent_t             cent_s5;

	logic [WD_W-1:0]    weekday_s6;
	logic [HOURF_W-1:0] hour_s6;
	logic [TQ_W-1:0]    tm_s6;
	logic [SECF_W-1:0]  second_s6;
	logic [DQ_W-1:0]    dq_s6;
	logic [DR_W-1:0]    dr_s6;
	cent_t              cent_s6;

	tod_t              tf_s7;
	logic [DQ_W-1:0]   d_s7;
	logic [E_W-1:0]    e_s7;
	cent_t             cent_s7;

	tod_t              tf_s8;
	logic [XM_W-1:0]   xm_s8;
	logic [PMQ_W-1:0]  pmq_s8;
	logic [E_W-1:0]    e_s8;
	logic [DQ_W-1:0]   d_s8;
	cent_t             cent_s8;

	tod_t              tf_s9;
	logic [MQ_W-1:0]   mq_s9;
	logic [MR_W-1:0]   mr_s9;
	logic [E_W-1:0]    e_s9;
	logic [DQ_W-1:0]   d_s9;
	cent_t             cent_s9;

	tod_t              tf_s10;
	logic [DOM_W-1:0]  dom_s10;
	logic [MON_W-1:0]  mon_s10;
	logic [YR_W-1:0]   yr_s10;

	// stage 4: weekday and time estimates, 100-year block of the julian day
	logic [WX_W-1:0] wx;
	logic [A_W-1:0]  a;
	logic [A_W-1:0]  c_full;
	cent_t           cent;

	assign wx = WX_W'(days) + WD_OFF;
	assign a  = A_W'(days) + A_OFF;

	always_comb begin
		if (a >= B69_A) begin
			cent   = CENT_2100;
			c_full = a - B69_A;
		end else if (a >= B68_A) begin
			cent   = CENT_2000;
			c_full = a - B68_A;
		end else begin
			cent   = CENT_1900;
			c_full = a - B67_A;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			wx_s4   <= wx;
			pw_s4   <= WP_W'(wx) * WP_W'(WD_REC);
			tod_s4  <= tod;
			ph_s4   <= PH_W'(tod) * PH_W'(HR_REC);
			pm_s4   <= PM_W'(tod) * PM_W'(TM_REC);
			c_s4    <= c_full[C_W-1:0];
			cent_s4 <= cent;
		end
	end

	// stage 5: remainders of the estimates, year-in-block estimate
	logic [WQ_W-1:0]  wq;
	logic [WX_W-1:0]  wr_full;
	logic [HQ_W-1:0]  hq;
	logic [TOD_W-1:0] hr_full;
	logic [TQ_W-1:0]  tq;
	logic [TOD_W-1:0] tr_full;
	logic [XD_W-1:0]  xd;

	assign wq      = pw_s4[WD_S +: WQ_W];
	assign wr_full = wx_s4 - WX_W'(wq) * WX_W'(WD_DAYS);
	assign hq      = ph_s4[TOD_S +: HQ_W];
	assign hr_full = tod_s4 - TOD_W'(hq) * TOD_W'(SEC_HOUR);
	assign tq      = pm_s4[TOD_S +: TQ_W];
	assign tr_full = tod_s4 - TOD_W'(tq) * TOD_W'(SEC_MIN);
	assign xd      = {c_s4, 2'b11};

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			wr_s5   <= wr_full[WR_W-1:0];
			hq_s5   <= hq;
			hr_s5   <= hr_full[HR_W-1:0];
			tq_s5   <= tq;
			tr_s5   <= tr_full[TR_W-1:0];
			xd_s5   <= xd;
			pd_s5   <= PD_W'(xd) * PD_W'(D_REC);
			cent_s5 <= cent_s4;
		end
	end

	// stage 6: time corrections, remainder of the year-in-block estimate
	logic [WR_W-1:0]  wd_fix;
	logic [TR_W-1:0]  sec_fix;
	logic             tr_over;
	logic [DQ_W-1:0]  dq;
	logic [XD_W-1:0]  dr_full;

	assign wd_fix  = (wr_s5 >= WD_DAYS) ? (wr_s5 - WD_DAYS) : wr_s5;
	assign tr_over = tr_s5 >= SEC_MIN;
	assign sec_fix = tr_over ? (tr_s5 - SEC_MIN) : tr_s5;
	assign dq      = pd_s5[D_S +: DQ_W];
	assign dr_full = xd_s5 - XD_W'(dq) * XD_W'(DAYS_4Y);

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			weekday_s6 <= wd_fix[WD_W-1:0];
			hour_s6    <= (hr_s5 >= SEC_HOUR) ? (hq_s5 + HOURF_W'(1)) : hq_s5;
			tm_s6      <= tr_over ? (tq_s5 + TQ_W'(1)) : tq_s5;
			second_s6  <= sec_fix[SECF_W-1:0];
			dq_s6      <= dq;
			dr_s6      <= dr_full[DR_W-1:0];
			cent_s6    <= cent_s5;
		end
	end

	// stage 7: minute of the hour, year in block and day of the march year
	logic [TQ_W-1:0] min_full;
	logic            dr_over;
	logic [DR_W-1:0] dr_fix;
	tod_t            tf;

	assign min_full   = tm_s6 - TQ_W'(hour_s6) * TQ_W'(SEC_MIN);
	assign dr_over    = dr_s6 >= DAYS_4Y;
	assign dr_fix     = dr_over ? (dr_s6 - DAYS_4Y) : dr_s6;
	assign tf.second  = second_s6;
	assign tf.minute  = min_full[MINF_W-1:0];
	assign tf.hour    = hour_s6;
	assign tf.weekday = weekday_s6;

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			tf_s7   <= tf;
			d_s7    <= dr_over ? (dq_s6 + DQ_W'(1)) : dq_s6;
			e_s7    <= dr_fix[E_W+1:2];
			cent_s7 <= cent_s6;
		end
	end

	// stage 8: month estimate from the day of the march year
	logic [XM_W-1:0] xm;

	assign xm = XM_W'(e_s7) * XM_W'(5) + XM_W'(2);

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			tf_s8   <= tf_s7;
			xm_s8   <= xm;
			pmq_s8  <= PMQ_W'(xm) * PMQ_W'(M_REC);
			e_s8    <= e_s7;
			d_s8    <= d_s7;
			cent_s8 <= cent_s7;
		end
	end

	// stage 9: remainder of the month estimate
	logic [MQ_W-1:0] mq;
	logic [XM_W-1:0] mr_full;

	assign mq      = pmq_s8[M_S +: MQ_W];
	assign mr_full = xm_s8 - XM_W'(mq) * XM_W'(DAYS_5M);

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			tf_s9   <= tf_s8;
			mq_s9   <= mq;
			mr_s9   <= mr_full[MR_W-1:0];
			e_s9    <= e_s8;
			d_s9    <= d_s8;
			cent_s9 <= cent_s8;
		end
	end

	// stage 10: month, day of month and year into the output register
	logic [MQ_W-1:0] m;
	logic            wrap;
	logic [E_W-1:0]  dom_full;

	assign m        = (mr_s9 >= DAYS_5M) ? (mq_s9 + MQ_W'(1)) : mq_s9;
	assign wrap     = m >= M_WRAP;
	assign dom_full = e_s9 - month_start(m) + E_W'(1);

	always_ff @(posedge clk) begin
		if (adv[9]) begin
			tf_s10  <= tf_s9;
			dom_s10 <= dom_full[DOM_W-1:0];
			mon_s10 <= wrap ? (m - MON_W'(9)) : (m + MON_W'(3));
			yr_s10  <= year_base(cent_s9) + YR_W'(d_s9) + YR_W'(wrap);
		end
	end

	// result fields
	assign cal.second_of_minute = tf_s10.second;
	assign cal.minute_of_hour   = tf_s10.minute;
	assign cal.hour_of_day      = tf_s10.hour;
	assign cal.weekday          = tf_s10.weekday;
	assign cal.day_of_month     = dom_s10;
	assign cal.month_number     = mon_s10;
	assign cal.year_number      = yr_s10;

endmodule

`default_nettype wire

@@ rtl/utc_pipe_ctl.sv @@
// valid bits and per-stage advance enables for the conversion pipeline
`default_nettype none

module utc_pipe_ctl #(
	parameter int unsigned NUM_STAGES = utc_pkg::NUM_STG
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [NUM_STAGES-1:0] adv
);
	import utc_pkg::*;

	logic [NUM_STAGES-1:0] valid_q;
	logic [NUM_STAGES-1:0] valid_d;

	// a stage loads when empty or when the stage after it moves on
	always_comb begin
		adv[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || out_ready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			adv[k] = !valid_q[k] || adv[k+1];
		end
	end

	assign valid_d   = {valid_q[NUM_STAGES-2:0], in_valid};
	assign in_ready  = adv[0];
	assign out_valid = valid_q[NUM_STAGES-1];

	// valid bits follow their requests down the pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int k = 0; k < NUM_STAGES; k++) begin
				if (adv[k]) begin
					valid_q[k] <= valid_d[k];
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/utc_day_split.sv @@
// splits seconds into whole days and seconds of the day over three stages
`default_nettype none

module utc_day_split (
	input  logic                           clk,
	input  logic [utc_pkg::SPLIT_STG-1:0]  adv,
	input  logic [utc_pkg::SEC_W-1:0]      unix_seconds,
	output logic [utc_pkg::DAY_W-1:0]      days,
	output logic [utc_pkg::TOD_W-1:0]      tod
);
	import utc_pkg::*;

	logic [PDAY_W-1:0]    p_day_s1;
	logic [HI_W-1:0]      hi_s1;
	logic [DAY_SHIFT-1:0] lo_s1;
	logic [DAY_W-1:0]     qd_s2;
	logic [DREM_W-1:0]    r0_s2;
	logic [DAY_SHIFT-1:0] lo_s2;
	logic [DAY_W-1:0]     days_s3;
	logic [TOD_W-1:0]     tod_s3;

	logic [HI_W-1:0]      hi;
	logic [DAY_W-1:0]     qd;
	logic [HI_W-1:0]      r0_full;
	logic                 fix;
	logic [DREM_W-1:0]    rc;

	// stage 1: quotient estimate by 675 on the seconds shifted by seven
	assign hi = unix_seconds[SEC_W-1:DAY_SHIFT];

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			hi_s1    <= hi;
			lo_s1    <= unix_seconds[DAY_SHIFT-1:0];
			p_day_s1 <= PDAY_W'(hi) * PDAY_W'(DAY_REC);
		end
	end

	// stage 2: remainder of the estimate, at most one divisor too large
	assign qd      = p_day_s1[DAY_REC_S +: DAY_W];
	assign r0_full = hi_s1 - HI_W'(qd) * HI_W'(DAY_ODD);

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			qd_s2 <= qd;
			r0_s2 <= r0_full[DREM_W-1:0];
			lo_s2 <= lo_s1;
		end
	end

	// stage 3: one correction step, then rebuild the seconds of the day
	assign fix = r0_s2 >= DREM_W'(DAY_ODD);
	assign rc  = fix ? (r0_s2 - DREM_W'(DAY_ODD)) : r0_s2;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			days_s3 <= fix ? (qd_s2 + DAY_W'(1)) : qd_s2;
			tod_s3  <= {rc[TOD_W-DAY_SHIFT-1:0], lo_s2};
		end
	end

	assign days = days_s3;
	assign tod  = tod_s3;

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// self-checking testbench for the unix time to calendar block

module testbench;

	import utc_pkg::*;

	// one calendar result, field for field as it leaves the block
	typedef struct {
		logic [SECF_W-1:0]  second_of_minute;
		logic [MINF_W-1:0]  minute_of_hour;
		logic [HOURF_W-1:0] hour_of_day;
		logic [WD_W-1:0]    weekday;
		logic [DOM_W-1:0]   day_of_month;
		logic [MON_W-1:0]   month_number;
		logic [YR_W-1:0]    year_number;
	} cal_fields_t;

	// expected calendar dates in request order, checked against each result
	class calendar_scoreboard;
		cal_fields_t expected_dates[$];
		int unsigned mismatches;
		int unsigned requests_noted;
		int unsigned results_checked;

		function new();
			mismatches      = 0;
			requests_noted  = 0;
			results_checked = 0;
		endfunction

		// day split, julian day number, then the integer gregorian conversion
		function cal_fields_t predict_calendar(input logic [SEC_W-1:0] secs);
			logic [31:0] days, tod, jdn, shifted, era, era_day, quad, year_day;
			logic [31:0] mar_month, wrap;
			cal_fields_t f;
			days      = secs / 32'd86400;
			tod       = secs % 32'd86400;
			jdn       = 32'd2440588 + days;
			shifted   = jdn + 32'd32044;
			era       = (32'd4 * shifted + 32'd3) / 32'd146097;
			era_day   = shifted - (32'd146097 * era) / 32'd4;
			quad      = (32'd4 * era_day + 32'd3) / 32'd1461;
			year_day  = era_day - (32'd1461 * quad) / 32'd4;
			mar_month = (32'd5 * year_day + 32'd2) / 32'd153;
			wrap      = mar_month / 32'd10;
			f.second_of_minute = SECF_W'(tod % 32'd60);
			f.minute_of_hour   = MINF_W'((tod / 32'd60) % 32'd60);
			f.hour_of_day      = HOURF_W'(tod / 32'd3600);
			f.weekday          = WD_W'(jdn % 32'd7);
			f.day_of_month     = DOM_W'(year_day - (32'd153 * mar_month + 32'd2) / 32'd5
				+ 32'd1);
			f.month_number     = MON_W'(mar_month + 32'd3 - 32'd12 * wrap);
			f.year_number      = YR_W'(32'd100 * era + quad + wrap - 32'd4800);
			return f;
		endfunction

		function void note_request(input logic [SEC_W-1:0] secs);
			expected_dates.push_back(predict_calendar(secs));
			requests_noted++;
		endfunction

		function int unsigned pending();
			return expected_dates.size();
		endfunction

		function void compare_field(input string name, input int unsigned want,
			input logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(input cal_fields_t got);
			cal_fields_t want;
			if (expected_dates.size() == 0) begin
				$display("%0t: result with no request outstanding, expected none, actual %0d-%0d-%0d",
					$time, got.year_number, got.month_number, got.day_of_month);
				mismatches++;
				return;
			end
			want = expected_dates.pop_front();
			results_checked++;
			compare_field("second_of_minute", want.second_of_minute, got.second_of_minute);
			compare_field("minute_of_hour", want.minute_of_hour, got.minute_of_hour);
			compare_field("hour_of_day", want.hour_of_day, got.hour_of_day);
			compare_field("weekday", want.weekday, got.weekday);
			compare_field("day_of_month", want.day_of_month, got.day_of_month);
			compare_field("month_number", want.month_number, got.month_number);
			compare_field("year_number", want.year_number, got.year_number);
		endfunction
	endclass

	typedef enum int unsigned {
		SINK_FREE,
		SINK_RANDOM,
		SINK_PERIODIC,
		SINK_LONG_STALL
	} sink_mode_t;

	localparam int unsigned RANDOM_STAMPS = 1250;

	logic clk;
	logic arst_n;

	utc_stamp_if stamp ();
	utc_cal_if   cal ();

	calendar_scoreboard sb = new();

	sink_mode_t  sink_mode;
	int unsigned sink_left;
	int unsigned sink_phase;
	int unsigned directed_count;

	// epoch, top of range, day, leap and century boundaries, alternating bits
	logic [SEC_W-1:0] directed_stamps[$] = '{
		32'd0, 32'hFFFF_FFFF, 32'd86399, 32'd86400, 32'd68169600,
		32'd946684799, 32'd946684800, 32'd951782400, 32'd951868799, 32'd951868800,
		32'd4107456000, 32'd4107542399, 32'd4107542400, 32'd1735689599,
		32'd2147483647, 32'd2147483648, 32'hAAAA_AAAA, 32'h5555_5555,
		32'hFFFE_AE80, 32'd3600, 32'd59
	};

	unix_time_to_calendar DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.stamp  (stamp),
		.cal    (cal)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// known levels from time zero
	initial begin
		arst_n             = 1'b0;
		stamp.valid        = 1'b0;
		stamp.unix_seconds = '0;
		cal.ready          = 1'b0;
		sink_mode          = SINK_FREE;
		sink_left          = 0;
		sink_phase         = 0;
	end

	// receiver stall pattern, switching among free, random, periodic and long-stall modes
	always @(negedge clk) begin
		if (sink_left == 0) begin
			sink_mode = sink_mode_t'($urandom_range(0, 3));
			sink_left = $urandom_range(8, 120);
		end else begin
			sink_left--;
		end
		sink_phase++;
		case (sink_mode)
			SINK_FREE:     cal.ready <= 1'b1;
			SINK_RANDOM:   cal.ready <= ($urandom_range(0, 3) != 0);
			SINK_PERIODIC: cal.ready <= ((sink_phase % 5) < 2);
			default:       cal.ready <= ((sink_phase % 37) >= 30);
		endcase
	end

	// note accepted requests and check accepted results
	always @(posedge clk) begin
		cal_fields_t got;
		if (arst_n) begin
			if (stamp.valid && stamp.ready)
				sb.note_request(stamp.unix_seconds);
			if (cal.valid && cal.ready) begin
				got.second_of_minute = cal.second_of_minute;
				got.minute_of_hour   = cal.minute_of_hour;
				got.hour_of_day      = cal.hour_of_day;
				got.weekday          = cal.weekday;
				got.day_of_month     = cal.day_of_month;
				got.month_number     = cal.month_number;
				got.year_number      = cal.year_number;
				sb.check_result(got);
			end
		end
	end

	// hold one request until accepted, return on the following falling edge
	task automatic send_stamp(input logic [SEC_W-1:0] secs);
		stamp.valid        <= 1'b1;
		stamp.unix_seconds <= secs;
		@(posedge clk);
		while (!stamp.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// idle the request side for a number of cycles
	task automatic pause_stamps(input int unsigned cycles);
		if (cycles != 0) begin
			stamp.valid <= 1'b0;
			repeat (cycles) @(negedge clk);
		end
	endtask

	// random timestamp, weighted towards day, century and range edges
	function automatic logic [SEC_W-1:0] pick_stamp();
		logic [SEC_W-1:0] secs;
		logic [SEC_W-1:0] day;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: secs = $urandom();
			4, 5: begin
				day  = $urandom_range(0, 49709);
				secs = day * 32'd86400;
				case ($urandom_range(0, 2))
					0:       secs = secs + 32'd86399;
					1:       secs = secs + 32'd3600 * $urandom_range(0, 23) - 32'd1;
					default: secs = secs;
				endcase
			end
			6: secs = 32'hFFFF_FFFF - $urandom_range(0, 40 * 86400);
			7: secs = 32'd951868800 + $urandom_range(0, 6 * 86400) - 32'd259200;
			8: secs = 32'd4107542400 + $urandom_range(0, 6 * 86400) - 32'd259200;
			default: secs = $urandom_range(0, 3 * 86400);
		endcase
		return secs;
	endfunction

	// reset, directed requests, random bursts, drain
	initial begin
		int unsigned sent;
		int unsigned burst;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		directed_count = directed_stamps.size();
		foreach (directed_stamps[i]) begin
			send_stamp(directed_stamps[i]);
			if ($urandom_range(0, 2) == 0)
				pause_stamps($urandom_range(1, 4));
		end

		sent = 0;
		while (sent < RANDOM_STAMPS) begin
			burst = $urandom_range(1, 40);
			while (burst != 0 && sent < RANDOM_STAMPS) begin
				send_stamp(pick_stamp());
				sent++;
				burst--;
			end
			if ($urandom_range(0, 3) != 0)
				pause_stamps($urandom_range(1, 12));
		end
		stamp.valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		$display("timestamps sent: %0d directed, %0d random; results checked: %0d",
			directed_count, RANDOM_STAMPS, sb.results_checked);
		$display("field mismatches or unexpected results: %0d", sb.mismatches);
		if (sb.mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// run limit
	initial begin
		#20000000;
		$display("timeout with %0d results still outstanding", sb.pending());
		$display("DONE: errors detected");
		$finish;
	end

endmodule
